>>> sv/tty_line_discipline_unit_defines.svh
// Assertion macros for the tty line discipline unit.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef TTY_LINE_DISCIPLINE_UNIT_DEFINES_SVH
`define TTY_LINE_DISCIPLINE_UNIT_DEFINES_SVH

`ifndef SYNTH
`define TLD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tld check failed");
`define TLD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tld check failed");
`else
`define TLD_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define TLD_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> sv/tld_pkg.sv
// Shared types and constants of the tty line discipline unit.
// No dependencies; used by the interfaces, controller, datapath and top level.
package tld_pkg;

    localparam int OP_W      = 2;
    localparam int BYTE_W    = 8;
    localparam int STATUS_W  = 3;
    localparam int ECHO_W    = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 48;
    localparam int N_IGNORED = 6;

    typedef logic [OP_W-1:0]      t_op;
    typedef logic [BYTE_W-1:0]    t_byte;
    typedef logic [STATUS_W-1:0]  t_status;
    typedef logic [ECHO_W-1:0]    t_echo;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    typedef logic [CFG_W-1:0]     t_cfg_data;

    localparam t_op OP_KEY   = 2'd0;
    localparam t_op OP_PULL  = 2'd1;
    localparam t_op OP_FLUSH = 2'd2;

    localparam t_status ST_KEY_TAKEN   = 3'd0;
    localparam t_status ST_KEY_DROPPED = 3'd1;
    localparam t_status ST_BYTE_GIVEN  = 3'd2;
    localparam t_status ST_RETURN      = 3'd3;
    localparam t_status ST_EOF         = 3'd4;
    localparam t_status ST_WAIT        = 3'd5;
    localparam t_status ST_FLUSHED     = 3'd6;

    localparam t_echo ECHO_NONE  = 2'd0;
    localparam t_echo ECHO_PRINT = 2'd1;
    localparam t_echo ECHO_ERASE = 2'd2;

    localparam t_cfg_idx CFG_CANONICAL = 3'd0;
    localparam t_cfg_idx CFG_ECHO      = 3'd1;
    localparam t_cfg_idx CFG_EOF       = 3'd2;
    localparam t_cfg_idx CFG_EOL       = 3'd3;
    localparam t_cfg_idx CFG_ERASE     = 3'd4;
    localparam t_cfg_idx CFG_IGNORED   = 3'd5;
    localparam t_cfg_idx CFG_MIN       = 3'd6;

    localparam t_byte     RST_EOF_CODE   = 8'd4;
    localparam t_byte     RST_EOL_CODE   = 8'd0;
    localparam t_byte     RST_ERASE_CODE = 8'd8;
    localparam t_cfg_data RST_IGNORED    = 48'h1A13_111C_1503;
    localparam t_byte     RST_MIN_BYTES  = 8'd1;

    localparam t_byte NEWLINE_CODE = 8'd10;
    localparam t_byte EOF_COUNT_MAX = 8'd255;

    typedef struct packed {
        logic capture;
        logic execute;
    } t_dp_cmd;

    typedef struct packed {
        t_status status;
        t_byte   data_byte;
        logic    line_done;
        t_echo   echo_action;
        t_byte   echo_byte;
    } t_rsp;

endpackage

>>> sv/tld_req_if.sv
// Request channel of the tty line discipline unit: valid, ready and one request.
// Depends on tld_pkg.
interface tld_req_if;
    logic           valid;
    logic           ready;
    tld_pkg::t_op   opcode;
    tld_pkg::t_byte key_byte;
    tld_pkg::t_byte bytes_so_far;

    modport source (output valid, output opcode, output key_byte, output bytes_so_far,
                    input ready);
    modport sink   (input valid, input opcode, input key_byte, input bytes_so_far,
                    output ready);
endinterface

>>> sv/tld_rsp_if.sv
// Response channel of the tty line discipline unit: valid, ready and one result.
// Depends on tld_pkg.
interface tld_rsp_if;
    logic             valid;
    logic             ready;
    tld_pkg::t_status status;
    tld_pkg::t_byte   data_byte;
    logic             line_done;
    tld_pkg::t_echo   echo_action;
    tld_pkg::t_byte   echo_byte;

    modport source (output valid, output status, output data_byte, output line_done,
                    output echo_action, output echo_byte, input ready);
    modport sink   (input valid, input status, input data_byte, input line_done,
                    input echo_action, input echo_byte, output ready);
endinterface

>>> sv/tld_ctrl.sv
// Controller of the tty line discipline unit: request capture, execute, result slot.
// Depends on tld_pkg and the assertion macro header.
`include "tty_line_discipline_unit_defines.svh"

module tld_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    output logic             o_req_ready,
    output logic             o_rsp_valid,
    input  logic             i_rsp_ready,
    output tld_pkg::t_dp_cmd o_cmd
);
    import tld_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic r_state;
    logic n_state;
    logic r_out_valid;
    logic n_out_valid;
    logic slot_free;

    assign slot_free     = !r_out_valid || i_rsp_ready;
    assign o_req_ready   = (r_state == S_IDLE);
    assign o_cmd.capture = i_req_valid && (r_state == S_IDLE);
    assign o_cmd.execute = (r_state == S_EXEC) && slot_free;
    assign o_rsp_valid   = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_rsp_ready;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (slot_free) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    `TLD_ASSERT_NXT(a_accept_goes_exec, i_clk, i_rst_n, i_req_valid && o_req_ready, r_state == S_EXEC)
    `TLD_ASSERT_NXT(a_execute_fills_slot, i_clk, i_rst_n, o_cmd.execute, r_out_valid && r_state == S_IDLE)
    `TLD_ASSERT_NXT(a_stall_holds_exec, i_clk, i_rst_n, r_state == S_EXEC && r_out_valid && !i_rsp_ready, r_state == S_EXEC)
    `TLD_ASSERT_IMP(a_no_accept_in_exec, i_clk, i_rst_n, r_state == S_EXEC, !o_req_ready && !o_cmd.capture)

endmodule

>>> sv/tld_datapath.sv
// Datapath of the tty line discipline unit: configuration, pointers, byte store,
// request and result registers. Depends on tld_pkg.
module tld_datapath #(
    parameter int STORE_DEPTH = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tld_pkg::t_dp_cmd    i_cmd,
    input  logic                i_cfg_we,
    input  tld_pkg::t_cfg_idx   i_cfg_idx,
    input  tld_pkg::t_cfg_data  i_cfg_wdata,
    input  tld_pkg::t_op        i_opcode,
    input  tld_pkg::t_byte      i_key_byte,
    input  tld_pkg::t_byte      i_bytes_so_far,
    output tld_pkg::t_rsp       o_rsp
);
    import tld_pkg::*;

    localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam logic [AW-1:0] LAST = AW'(STORE_DEPTH - 1);

    logic            r_canonical;
    logic            r_echo_en;
    t_byte           r_eof_code;
    t_byte           r_eol_code;
    t_byte           r_erase_code;
    t_cfg_data       r_ignored;
    t_byte           r_min_bytes;

    logic [AW-1:0]   r_wr_ptr;
    logic [AW-1:0]   r_cm_ptr;
    logic [AW-1:0]   r_rd_ptr;
    t_byte           r_eofs;
    logic [AW-1:0]   n_wr_ptr;
    logic [AW-1:0]   n_cm_ptr;
    logic [AW-1:0]   n_rd_ptr;
    t_byte           n_eofs;

    t_op             r_op;
    t_byte           r_key;
    t_byte           r_sofar;

    t_byte           r_store [STORE_DEPTH];
    t_byte           r_rdata;
    logic            mem_we;

    t_rsp            r_rsp;
    t_rsp            n_rsp;

    logic [AW-1:0]   wr_next;
    logic [AW-1:0]   wr_prev;
    logic [AW-1:0]   rd_next;
    logic            full;
    logic            ignored_hit;
    logic            do_store;
    logic            do_commit;

    assign wr_next = (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;
    assign wr_prev = (r_wr_ptr == '0) ? LAST : r_wr_ptr - 1'b1;
    assign rd_next = (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
    assign full    = (wr_next == r_rd_ptr);

    always_comb begin
        ignored_hit = 1'b0;
        for (int k = 0; k < N_IGNORED; k++) begin
            if (r_ignored[k*BYTE_W +: BYTE_W] == r_key) begin
                ignored_hit = 1'b1;
            end
        end
    end

    always_comb begin
        n_wr_ptr  = r_wr_ptr;
        n_cm_ptr  = r_cm_ptr;
        n_rd_ptr  = r_rd_ptr;
        n_eofs    = r_eofs;
        n_rsp     = '0;
        do_store  = 1'b0;
        do_commit = 1'b0;
        mem_we    = 1'b0;
        case (r_op)
            OP_KEY: begin
                n_rsp.status = ST_KEY_TAKEN;
                if (!r_canonical) begin
                    do_store  = 1'b1;
                    do_commit = 1'b1;
                end else if (r_key == r_eof_code) begin
                    if (r_cm_ptr != r_wr_ptr) begin
                        n_cm_ptr = r_wr_ptr;
                    end else if (r_eofs != EOF_COUNT_MAX) begin
                        n_eofs = r_eofs + 1'b1;
                    end
                end else if (r_key == r_eol_code) begin
                    n_rsp.status = ST_KEY_TAKEN;
                end else if (r_key == r_erase_code) begin
                    if (r_cm_ptr != r_wr_ptr) begin
                        n_wr_ptr = wr_prev;
                        if (r_echo_en) begin
                            n_rsp.echo_action = ECHO_ERASE;
                        end
                    end
                end else if (!ignored_hit) begin
                    do_store  = 1'b1;
                    do_commit = (r_key == NEWLINE_CODE);
                end
                if (do_store) begin
                    if (full) begin
                        n_rsp.status = ST_KEY_DROPPED;
                    end else begin
                        mem_we   = i_cmd.execute;
                        n_wr_ptr = wr_next;
                        if (do_commit) begin
                            n_cm_ptr = wr_next;
                        end
                        if (r_echo_en) begin
                            n_rsp.echo_action = ECHO_PRINT;
                            n_rsp.echo_byte   = r_key;
                        end
                    end
                end
            end
            OP_PULL: begin
                if (r_cm_ptr == r_rd_ptr && r_eofs == '0) begin
                    if (r_canonical) begin
                        n_rsp.status = (r_sofar != '0) ? ST_RETURN : ST_WAIT;
                    end else begin
                        n_rsp.status = (r_sofar >= r_min_bytes) ? ST_RETURN : ST_WAIT;
                    end
                end else if (r_eofs != '0) begin
                    if (r_sofar != '0) begin
                        n_rsp.status = ST_RETURN;
                    end else begin
                        n_eofs       = r_eofs - 1'b1;
                        n_rsp.status = ST_EOF;
                    end
                end else begin
                    n_rd_ptr        = rd_next;
                    n_rsp.status    = ST_BYTE_GIVEN;
                    n_rsp.data_byte = r_rdata;
                    n_rsp.line_done = r_canonical && (r_rdata == NEWLINE_CODE);
                end
            end
            OP_FLUSH: begin
                n_wr_ptr     = '0;
                n_cm_ptr     = '0;
                n_rd_ptr     = '0;
                n_eofs       = '0;
                n_rsp.status = ST_FLUSHED;
            end
            default: begin
                n_rsp.status = ST_WAIT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_canonical  <= 1'b1;
            r_echo_en    <= 1'b1;
            r_eof_code   <= RST_EOF_CODE;
            r_eol_code   <= RST_EOL_CODE;
            r_erase_code <= RST_ERASE_CODE;
            r_ignored    <= RST_IGNORED;
            r_min_bytes  <= RST_MIN_BYTES;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CANONICAL: r_canonical  <= i_cfg_wdata[0];
                CFG_ECHO:      r_echo_en    <= i_cfg_wdata[0];
                CFG_EOF:       r_eof_code   <= i_cfg_wdata[BYTE_W-1:0];
                CFG_EOL:       r_eol_code   <= i_cfg_wdata[BYTE_W-1:0];
                CFG_ERASE:     r_erase_code <= i_cfg_wdata[BYTE_W-1:0];
                CFG_IGNORED:   r_ignored    <= i_cfg_wdata;
                CFG_MIN:       r_min_bytes  <= i_cfg_wdata[BYTE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_cm_ptr <= '0;
            r_rd_ptr <= '0;
            r_eofs   <= '0;
        end else if (i_cmd.execute) begin
            r_wr_ptr <= n_wr_ptr;
            r_cm_ptr <= n_cm_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_eofs   <= n_eofs;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op    <= i_opcode;
            r_key   <= i_key_byte;
            r_sofar <= i_bytes_so_far;
        end
        if (i_cmd.execute) begin
            r_rsp <= n_rsp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_store[r_wr_ptr] <= r_key;
        end
        r_rdata <= r_store[r_rd_ptr];
    end

    assign o_rsp = r_rsp;

endmodule

>>> sv/tty_line_discipline_unit.sv
// Top level of the tty line discipline unit: controller plus datapath.
// Depends on tld_pkg, tld_req_if, tld_rsp_if, tld_ctrl and tld_datapath.
//
// A request is captured at its accepting edge while the byte store reads at the read
// pointer. In the execute state it works on the registered read data, updates the
// pointers and loads the result, which is valid from then on. Execution holds only
// while the previous result has not been taken. A finished result waits in the
// output register. The next request is accepted in the cycle after execution, so the
// unit takes no new request before it is through with the last one.
// Configuration writes take effect at the clock edge of the write enable and must
// be issued only when no request is in flight. STORE_DEPTH sets the circular store
// size; it holds at most STORE_DEPTH - 1 bytes, and store entries need no reset.
module tty_line_discipline_unit #(
    parameter int STORE_DEPTH = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    tld_req_if.sink            i_req,
    tld_rsp_if.source          o_rsp,
    input  logic               i_cfg_we,
    input  tld_pkg::t_cfg_idx  i_cfg_idx,
    input  tld_pkg::t_cfg_data i_cfg_wdata
);
    import tld_pkg::*;

    t_dp_cmd cmd;
    t_rsp    rsp;
    logic    req_ready;
    logic    rsp_valid;

    tld_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (req_ready),
        .o_rsp_valid (rsp_valid),
        .i_rsp_ready (o_rsp.ready),
        .o_cmd       (cmd)
    );

    tld_datapath #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_opcode       (i_req.opcode),
        .i_key_byte     (i_req.key_byte),
        .i_bytes_so_far (i_req.bytes_so_far),
        .o_rsp          (rsp)
    );

    assign i_req.ready       = req_ready;
    assign o_rsp.valid       = rsp_valid;
    assign o_rsp.status      = rsp.status;
    assign o_rsp.data_byte   = rsp.data_byte;
    assign o_rsp.line_done   = rsp.line_done;
    assign o_rsp.echo_action = rsp.echo_action;
    assign o_rsp.echo_byte   = rsp.echo_byte;

endmodule

>>> bench/tld_checker.sv
// Response checker for the tty line discipline unit: tracks config writes and requests,
// predicts each response from its own copy of the line state and compares.
// Depends on tld_pkg, tld_req_if and tld_rsp_if.
module tld_checker #(
    parameter int STORE_DEPTH = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    tld_req_if                 i_req,
    tld_rsp_if                 i_rsp,
    input  logic               i_cfg_we,
    input  tld_pkg::t_cfg_idx  i_cfg_idx,
    input  tld_pkg::t_cfg_data i_cfg_wdata,
    output int                 o_fail_count,
    output int                 o_pending
);
    import tld_pkg::*;

    t_byte       char_mem [STORE_DEPTH];
    int unsigned wr_pos;
    int unsigned commit_pos;
    int unsigned rd_pos;
    t_byte       eof_count;

    logic        canon;
    logic        echo_on;
    t_byte       eof_chr;
    t_byte       eol_chr;
    t_byte       erase_chr;
    t_cfg_data   skip_codes;
    t_byte       min_cnt;

    t_rsp        expected_rsp_q [$];
    int          fails = 0;

    function automatic void reset_line_state();
        for (int i = 0; i < STORE_DEPTH; i++) char_mem[i] = '0;
        wr_pos     = 0;
        commit_pos = 0;
        rd_pos     = 0;
        eof_count  = '0;
        canon      = 1'b1;
        echo_on    = 1'b1;
        eof_chr    = RST_EOF_CODE;
        eol_chr    = RST_EOL_CODE;
        erase_chr  = RST_ERASE_CODE;
        skip_codes = RST_IGNORED;
        min_cnt    = RST_MIN_BYTES;
    endfunction

    function automatic void apply_cfg(t_cfg_idx idx, t_cfg_data val);
        case (idx)
            CFG_CANONICAL: canon = val[0];
            CFG_ECHO:      echo_on = val[0];
            CFG_EOF:       eof_chr = val[7:0];
            CFG_EOL:       eol_chr = val[7:0];
            CFG_ERASE:     erase_chr = val[7:0];
            CFG_IGNORED:   skip_codes = val;
            CFG_MIN:       min_cnt = val[7:0];
            default: ;
        endcase
    endfunction

    function automatic int unsigned advance(int unsigned p);
        return (p + 1 >= STORE_DEPTH) ? 0 : p + 1;
    endfunction

    function automatic bit is_skipped(t_byte b);
        for (int k = 0; k < N_IGNORED; k++) begin
            if (skip_codes[8*k +: 8] == b) return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic t_rsp store_key(t_byte b, bit commit);
        t_rsp r;
        r = '0;
        if (advance(wr_pos) == rd_pos) begin
            r.status = ST_KEY_DROPPED;
            return r;
        end
        char_mem[wr_pos] = b;
        wr_pos = advance(wr_pos);
        if (commit) commit_pos = wr_pos;
        r.status = ST_KEY_TAKEN;
        if (echo_on) begin
            r.echo_action = ECHO_PRINT;
            r.echo_byte   = b;
        end
        return r;
    endfunction

    function automatic t_rsp take_key(t_byte b);
        t_rsp r;
        r = '0;
        r.status = ST_KEY_TAKEN;
        if (!canon) return store_key(b, 1'b1);
        if (b == eof_chr) begin
            if (commit_pos != wr_pos) commit_pos = wr_pos;
            else if (eof_count != EOF_COUNT_MAX) eof_count++;
        end else if (b == erase_chr && b != eol_chr) begin
            if (commit_pos != wr_pos) begin
                wr_pos = (wr_pos == 0) ? STORE_DEPTH - 1 : wr_pos - 1;
                if (echo_on) r.echo_action = ECHO_ERASE;
            end
        end else if (b != eol_chr && b != erase_chr && !is_skipped(b)) begin
            r = store_key(b, b == NEWLINE_CODE);
        end
        return r;
    endfunction

    function automatic t_rsp pull_byte(t_byte so_far);
        t_rsp        r;
        int unsigned avail;
        r = '0;
        avail = (commit_pos + STORE_DEPTH - rd_pos) % STORE_DEPTH;
        if (eof_count != 0) begin
            if (so_far != 0) begin
                r.status = ST_RETURN;
            end else begin
                eof_count--;
                r.status = ST_EOF;
            end
        end else if (avail == 0) begin
            if (canon) r.status = (so_far != 0) ? ST_RETURN : ST_WAIT;
            else       r.status = (so_far >= min_cnt) ? ST_RETURN : ST_WAIT;
        end else begin
            r.status    = ST_BYTE_GIVEN;
            r.data_byte = char_mem[rd_pos];
            r.line_done = canon && (r.data_byte == NEWLINE_CODE);
            rd_pos      = advance(rd_pos);
        end
        return r;
    endfunction

    function automatic t_rsp line_response(t_op op, t_byte key, t_byte so_far);
        t_rsp r;
        r = '0;
        case (op)
            OP_KEY:  r = take_key(key);
            OP_PULL: r = pull_byte(so_far);
            OP_FLUSH: begin
                wr_pos     = 0;
                commit_pos = 0;
                rd_pos     = 0;
                eof_count  = '0;
                r.status   = ST_FLUSHED;
            end
            default: r.status = ST_WAIT;
        endcase
        return r;
    endfunction

    function automatic int field_mismatch(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge i_clk) begin
        t_rsp got;
        t_rsp want;
        if (!i_rst_n) begin
            reset_line_state();
            expected_rsp_q.delete();
        end else begin
            if (i_cfg_we) apply_cfg(i_cfg_idx, i_cfg_wdata);
            if (i_rsp.valid && i_rsp.ready) begin
                got.status      = i_rsp.status;
                got.data_byte   = i_rsp.data_byte;
                got.line_done   = i_rsp.line_done;
                got.echo_action = i_rsp.echo_action;
                got.echo_byte   = i_rsp.echo_byte;
                if (expected_rsp_q.size() == 0) begin
                    $error("unexpected response with status %0d", got.status);
                    fails++;
                end else begin
                    want = expected_rsp_q.pop_front();
                    fails += field_mismatch("status", 8'(want.status), 8'(got.status));
                    fails += field_mismatch("data_byte", want.data_byte, got.data_byte);
                    fails += field_mismatch("line_done", 8'(want.line_done), 8'(got.line_done));
                    fails += field_mismatch("echo_action", 8'(want.echo_action),
                                            8'(got.echo_action));
                    fails += field_mismatch("echo_byte", want.echo_byte, got.echo_byte);
                end
            end
            if (i_req.valid && i_req.ready) begin
                expected_rsp_q.push_back(line_response(i_req.opcode, i_req.key_byte,
                                                       i_req.bytes_so_far));
            end
        end
        o_fail_count <= fails;
        o_pending    <= expected_rsp_q.size();
    end

endmodule

>>> bench/testbench.sv
// Top of the tty line discipline unit regression: clock, reset, request stimulus,
// response stalls, config phases and the verdict.
// Depends on tld_pkg, tld_req_if, tld_rsp_if, tty_line_discipline_unit and tld_checker.
module testbench;
    import tld_pkg::*;

    localparam int  STORE_DEPTH = 256;
    localparam int  IDLE_LIMIT  = 2000;
    localparam t_op OP_UNUSED   = 2'd3;

    logic      i_clk;
    logic      i_rst_n;
    logic      cfg_we;
    t_cfg_idx  cfg_idx;
    t_cfg_data cfg_wdata;
    int        fail_count;
    int        pending;
    int        idle_cycles = 0;
    int        burst_left = 0;

    t_byte     cur_eof;
    t_byte     cur_eol;
    t_byte     cur_erase;
    t_cfg_data cur_skip;
    t_byte     cur_min;

    tld_req_if req_ch ();
    tld_rsp_if rsp_ch ();

    tty_line_discipline_unit #(.STORE_DEPTH(STORE_DEPTH)) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_ch),
        .o_rsp       (rsp_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata)
    );

    tld_checker #(.STORE_DEPTH(STORE_DEPTH)) i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_ch),
        .i_rsp        (rsp_ch),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_wdata  (cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("tty_line_discipline_unit regression: fail");
            $finish;
        end
    end

    initial begin : rsp_stall
        int stall_left;
        int calm_left;
        stall_left = 0;
        calm_left  = 0;
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (calm_left > 0) begin
                calm_left--;
                rsp_ch.ready <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= 1'b1;
                case ($urandom_range(0, 9))
                    0, 1, 2: stall_left = $urandom_range(1, 6);
                    3:       calm_left = $urandom_range(20, 120);
                    default: ;
                endcase
            end
        end
    end

    task automatic send_request(t_op op, t_byte key, t_byte so_far);
        if (burst_left == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = $urandom_range(1, 60);
        end
        burst_left--;
        req_ch.valid        <= 1'b1;
        req_ch.opcode       <= op;
        req_ch.key_byte     <= key;
        req_ch.bytes_so_far <= so_far;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, t_cfg_data val);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= val;
        @(posedge i_clk);
    endtask

    task automatic configure(logic canon, logic echo, t_byte eof, t_byte eol, t_byte erase,
                             t_cfg_data skip, t_byte min_cnt);
        drain();
        write_reg(CFG_CANONICAL, t_cfg_data'(canon));
        write_reg(CFG_ECHO, t_cfg_data'(echo));
        write_reg(CFG_EOF, t_cfg_data'(eof));
        write_reg(CFG_EOL, t_cfg_data'(eol));
        write_reg(CFG_ERASE, t_cfg_data'(erase));
        write_reg(CFG_IGNORED, skip);
        write_reg(CFG_MIN, t_cfg_data'(min_cnt));
        cfg_we    <= 1'b0;
        cur_eof   = eof;
        cur_eol   = eol;
        cur_erase = erase;
        cur_skip  = skip;
        cur_min   = min_cnt;
    endtask

    task automatic random_request(int key_pct, int flush_pct);
        int    roll;
        t_op   op;
        t_byte key;
        t_byte so_far;
        roll = $urandom_range(0, 99);
        if (roll < flush_pct) op = OP_FLUSH;
        else if (roll < flush_pct + key_pct) op = OP_KEY;
        else op = OP_PULL;
        case ($urandom_range(0, 19))
            0, 1:    key = cur_eof;
            2:       key = cur_eol;
            3, 4:    key = cur_erase;
            5:       key = cur_skip[8*$urandom_range(0, 5) +: 8];
            6, 7, 8: key = NEWLINE_CODE;
            9, 10, 11, 12, 13, 14: key = t_byte'($urandom_range(32, 126));
            default: key = t_byte'($urandom_range(0, 255));
        endcase
        case ($urandom_range(0, 7))
            0, 1, 2: so_far = '0;
            3:       so_far = t_byte'($urandom_range(1, 3));
            4:       so_far = cur_min;
            5:       so_far = cur_min - 8'd1;
            default: so_far = t_byte'($urandom_range(0, 255));
        endcase
        send_request(op, key, so_far);
    endtask

    initial begin : stimulus
        req_ch.valid        <= 1'b0;
        req_ch.opcode       <= OP_KEY;
        req_ch.key_byte     <= '0;
        req_ch.bytes_so_far <= '0;
        cfg_we              <= 1'b0;
        cfg_idx             <= CFG_CANONICAL;
        cfg_wdata           <= '0;
        i_rst_n             <= 1'b0;
        cur_eof   = RST_EOF_CODE;
        cur_eol   = RST_EOL_CODE;
        cur_erase = RST_ERASE_CODE;
        cur_skip  = RST_IGNORED;
        cur_min   = RST_MIN_BYTES;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_request(OP_KEY, 8'h61, '0);
        send_request(OP_KEY, RST_ERASE_CODE, '0);
        send_request(OP_KEY, RST_ERASE_CODE, '0);
        send_request(OP_KEY, RST_EOL_CODE, '0);
        send_request(OP_KEY, RST_IGNORED[7:0], '0);
        send_request(OP_KEY, 8'hFF, '0);
        send_request(OP_KEY, RST_EOF_CODE, '0);
        send_request(OP_KEY, RST_EOF_CODE, '0);
        send_request(OP_PULL, '0, 8'hFF);
        send_request(OP_PULL, 8'hFF, '0);
        send_request(OP_PULL, '0, '0);
        send_request(OP_PULL, '0, '0);
        send_request(OP_PULL, '0, 8'd1);
        send_request(OP_KEY, NEWLINE_CODE, '0);
        send_request(OP_KEY, RST_ERASE_CODE, '0);
        send_request(OP_PULL, '0, '0);
        send_request(OP_KEY, 8'h41, '0);
        send_request(OP_FLUSH, '0, '0);
        send_request(OP_PULL, '0, '0);
        send_request(OP_UNUSED, '0, '0);

        configure(1'b1, 1'b1, RST_EOF_CODE, RST_EOL_CODE, RST_ERASE_CODE, RST_IGNORED,
                  RST_MIN_BYTES);
        repeat (75) random_request(50, 2);
        drain();
        repeat (75) random_request(50, 2);

        configure(1'b0, 1'b0, RST_EOF_CODE, RST_EOL_CODE, RST_ERASE_CODE, RST_IGNORED, 8'd0);
        repeat (150) random_request(50, 2);

        // fill past capacity so keys get dropped, then drain part of it with mostly pulls
        configure(1'b0, 1'b1, 8'd4, 8'd0, 8'd8, 48'h0123_4567_89AB, 8'd255);
        repeat (280) random_request(100, 0);
        repeat (80) random_request(20, 0);

        configure(1'b1, 1'b1, 8'd0, 8'd0, NEWLINE_CODE, 48'h0, 8'd0);
        repeat (150) random_request(50, 2);

        // saturate the end-of-file counter
        configure(1'b1, 1'b0, 8'hFF, 8'hFE, 8'h7F, 48'hFFFF_FFFF_FFFF, 8'd128);
        repeat (270) send_request(OP_KEY, cur_eof, '0);
        repeat (60) random_request(0, 0);

        configure(1'b1, 1'b1, 8'd4, 8'h7F, 8'h08, 48'h1A13_111C_1503, 8'd255);
        repeat (150) random_request(50, 2);

        drain();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tty_line_discipline_unit regression: pass");
        end else begin
            $display("tty_line_discipline_unit regression: fail");
        end
        $finish;
    end

endmodule
